// File: rtl/coalescing_command_queue_macros.svh
// Assertion macros shared by the coalescing command queue RTL.
// Each expects a clock named clk and a synchronous reset named rst in scope.
`ifndef COALESCING_COMMAND_QUEUE_MACROS_SVH
`define COALESCING_COMMAND_QUEUE_MACROS_SVH

// Same-cycle implication, idle under reset.
`define CCQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, idle under reset.
`define CCQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ccq_pkg.sv
// Shared types and constants for the coalescing command queue.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package ccq_pkg;

  localparam int QUEUE_SLOTS_DEF = 8;
  localparam int KEY_W           = 16;
  localparam int VAL_W           = 16;
  localparam int OCC_W           = 3;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP,
    ST_FINISH
  } seq_state_t;

  // Port controls from the sequencer to the entry memory.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  // One finished result.
  typedef struct packed {
    logic             pop_valid;
    logic [KEY_W-1:0] out_key;
    logic [VAL_W-1:0] out_value;
    logic             merged;
    logic             dropped_oldest;
    logic [OCC_W-1:0] occupancy;
  } result_t;

endpackage

// File: rtl/ccq_if.sv
// Valid/ready channel interfaces for the coalescing command queue.
// Depends on ccq_pkg for field widths.
`timescale 1ns / 1ps

interface ccq_req_if;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [ccq_pkg::KEY_W-1:0] key;
  logic [ccq_pkg::VAL_W-1:0] value;

  modport source (output valid, command, key, value, input ready);
  modport sink   (input valid, command, key, value, output ready);
endinterface

interface ccq_rsp_if;
  logic                     valid;
  logic                     ready;
  logic                     pop_valid;
  logic [ccq_pkg::KEY_W-1:0] out_key;
  logic [ccq_pkg::VAL_W-1:0] out_value;
  logic                     merged;
  logic                     dropped_oldest;
  logic [ccq_pkg::OCC_W-1:0] occupancy;

  modport source (output valid, pop_valid, out_key, out_value, merged, dropped_oldest,
                  occupancy, input ready);
  modport sink   (input valid, pop_valid, out_key, out_value, merged, dropped_oldest,
                  occupancy, output ready);
endinterface

// File: rtl/ccq_mem.sv
// Entry storage: key and value arrays, one write and one registered read port.
// Depends on ccq_pkg.
`timescale 1ns / 1ps

module ccq_mem #(
  parameter int QUEUE_SLOTS = ccq_pkg::QUEUE_SLOTS_DEF,
  parameter int PTR_W       = $clog2(QUEUE_SLOTS)
) (
  input  logic                      clk,
  input  ccq_pkg::mem_ctl_t         mem_ctl,
  input  logic [PTR_W-1:0]          wr_addr,
  input  logic [ccq_pkg::KEY_W-1:0] wr_key,
  input  logic [ccq_pkg::VAL_W-1:0] wr_value,
  input  logic [PTR_W-1:0]          rd_addr,
  output logic [ccq_pkg::KEY_W-1:0] rd_key,
  output logic [ccq_pkg::VAL_W-1:0] rd_value
);
  import ccq_pkg::*;

  logic [KEY_W-1:0] key_mem   [QUEUE_SLOTS];
  logic [VAL_W-1:0] value_mem [QUEUE_SLOTS];

  // Write port
  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      key_mem[wr_addr]   <= wr_key;
      value_mem[wr_addr] <= wr_value;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rd_key   <= key_mem[rd_addr];
      rd_value <= value_mem[rd_addr];
    end
  end

endmodule

// File: rtl/ccq_seq.sv
// Sequencer for the coalescing queue: ring pointers, key scan with one shared
// comparator, append/drop/pop decisions. Depends on ccq_pkg and ccq_mem.
`timescale 1ns / 1ps
`include "coalescing_command_queue_macros.svh"

module ccq_seq #(
  parameter int QUEUE_SLOTS = ccq_pkg::QUEUE_SLOTS_DEF,
  parameter int PTR_W       = $clog2(QUEUE_SLOTS)
) (
  input  logic                      clk,
  input  logic                      rst,
  // item side
  input  logic                      item_valid,
  output logic                      item_ready,
  input  logic                      item_command,
  input  logic [ccq_pkg::KEY_W-1:0] item_key,
  input  logic [ccq_pkg::VAL_W-1:0] item_value,
  // result side
  output logic                      res_valid,
  input  logic                      res_ready,
  output ccq_pkg::result_t          res
);
  import ccq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_SLOTS + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_SLOTS - 1);

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  seq_state_t       state, state_next;
  cmd_e_t           cmd;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;
  logic [PTR_W-1:0] oldest_ptr, free_ptr, scan_ptr, cmp_addr;
  logic             cmp_valid;
  logic             res_pop_valid, res_merged, res_dropped;
  logic [KEY_W-1:0] res_key;
  logic [VAL_W-1:0] res_value;
  logic [CNT_W-1:0] count;
  logic             accept, hit, empty, full;

  mem_ctl_t         mem_ctl;
  logic [PTR_W-1:0] wr_addr, rd_addr;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_value;

  ccq_mem #(
    .QUEUE_SLOTS (QUEUE_SLOTS),
    .PTR_W       (PTR_W)
  ) u_mem (
    .clk      (clk),
    .mem_ctl  (mem_ctl),
    .wr_addr  (wr_addr),
    .wr_key   (key),
    .wr_value (value),
    .rd_addr  (rd_addr),
    .rd_key   (rd_key),
    .rd_value (rd_value)
  );

  // Status
  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign empty      = (oldest_ptr == free_ptr);
  assign full       = (ring_next(free_ptr) == oldest_ptr);
  assign hit        = cmp_valid && (rd_key == key);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_e_t'(item_command) == CMD_POP) begin
            state_next = empty ? ST_FINISH : ST_POP;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit || (scan_ptr == free_ptr)) begin
          state_next = ST_FINISH;
        end
      end
      ST_POP:    state_next = ST_FINISH;
      ST_FINISH: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Memory port control: one read or one write per cycle
  always_comb begin
    mem_ctl = '0;
    rd_addr = scan_ptr;
    wr_addr = free_ptr;
    case (state)
      ST_IDLE: begin
        if (accept && cmd_e_t'(item_command) == CMD_POP && !empty) begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = oldest_ptr;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          mem_ctl.wr_en = 1'b1;
          wr_addr       = cmp_addr;
        end else if (scan_ptr != free_ptr) begin
          mem_ctl.rd_en = 1'b1;
        end else begin
          mem_ctl.wr_en = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pointers and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_ptr <= '0;
      free_ptr   <= '0;
      cmp_valid  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          cmp_valid <= 1'b0;
        end
        ST_SCAN: begin
          if (!hit && scan_ptr != free_ptr) begin
            cmp_valid <= 1'b1;
          end else if (!hit) begin
            if (full) begin
              oldest_ptr <= ring_next(oldest_ptr);
            end
            free_ptr <= ring_next(free_ptr);
          end
        end
        ST_POP: begin
          oldest_ptr <= ring_next(oldest_ptr);
        end
        default: ;
      endcase
    end
  end

  // Item capture, scan address and result fields
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd           <= cmd_e_t'(item_command);
          key           <= item_key;
          value         <= item_value;
          scan_ptr      <= oldest_ptr;
          res_pop_valid <= 1'b0;
          res_merged    <= 1'b0;
          res_dropped   <= 1'b0;
          res_key       <= '0;
          res_value     <= '0;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_merged <= 1'b1;
        end else if (scan_ptr != free_ptr) begin
          cmp_addr <= scan_ptr;
          scan_ptr <= ring_next(scan_ptr);
        end else begin
          res_dropped <= full;
        end
      end
      ST_POP: begin
        res_pop_valid <= 1'b1;
        res_key       <= rd_key;
        res_value     <= rd_value;
      end
      default: ;
    endcase
  end

  // Fill level from the settled pointers
  always_comb begin
    if (free_ptr >= oldest_ptr) begin
      count = CNT_W'(free_ptr - oldest_ptr);
    end else begin
      count = CNT_W'(QUEUE_SLOTS) - CNT_W'(oldest_ptr) + CNT_W'(free_ptr);
    end
  end

  assign res_valid          = (state == ST_FINISH);
  assign res.pop_valid      = res_pop_valid;
  assign res.out_key        = res_key;
  assign res.out_value      = res_value;
  assign res.merged         = res_merged;
  assign res.dropped_oldest = res_dropped;
  assign res.occupancy      = OCC_W'(count);

  // Checks
  `CCQ_ASSERT_NOW(a_ptr_range, 1'b1, (oldest_ptr <= LAST) && (free_ptr <= LAST), "ring pointer out of range")
  `CCQ_ASSERT_NOW(a_merge_excl, res_valid && res.merged, !res.dropped_oldest && !res.pop_valid && cmd == CMD_PUSH, "merge flagged with drop or pop")
  `CCQ_ASSERT_NEXT(a_empty_pop, accept && cmd_e_t'(item_command) == CMD_POP && empty, state == ST_FINISH && !res.pop_valid, "empty pop did not finish at once")
  `CCQ_ASSERT_NOW(a_one_port, 1'b1, !(mem_ctl.wr_en && mem_ctl.rd_en), "memory read and write in one cycle")

endmodule

// File: rtl/coalescing_command_queue.sv
// Coalescing command queue: ring of key/value pairs with in-place update and
// drop-oldest on overflow.
//
// Channels: request carries command/key/value, response carries one result per
// request; both transfer when valid and ready are high at a rising clk edge.
// A push scans the queued entries oldest first through one shared key
// comparator, one entry per cycle; a matching key gets its value replaced,
// otherwise the pair is appended and, when full, the oldest entry is dropped.
// A pop reads the oldest pair from the entry memory, or reports empty.
// A push stops its scan at the first matching key, else after the newest entry;
// the scan loop runs over the memory read port. A pop passes ST_POP on its way
// to ST_FINISH, an empty pop skips it. One request is in work at a time;
// request.ready is high only while the sequencer is idle.
// The result sits in an output register, so the next request is taken while it
// waits; a stalled receiver holds the sequencer only once its next result is done.
// Reset (rst, synchronous) empties the queue at once; entry memory is not cleared.
// Depends on ccq_pkg, ccq_if, ccq_mem and ccq_seq.
`timescale 1ns / 1ps

module coalescing_command_queue #(
  parameter int QUEUE_SLOTS = ccq_pkg::QUEUE_SLOTS_DEF
) (
  input logic      clk,
  input logic      rst,
  ccq_req_if.sink  request,
  ccq_rsp_if.source response
);
  import ccq_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_SLOTS);

  logic    res_valid, res_ready;
  result_t res, out_reg;
  logic    out_valid;

  ccq_seq #(
    .QUEUE_SLOTS (QUEUE_SLOTS),
    .PTR_W       (PTR_W)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (request.valid),
    .item_ready   (request.ready),
    .item_command (request.command),
    .item_key     (request.key),
    .item_value   (request.value),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // Output register: loads when empty or being drained
  assign res_ready = !out_valid || response.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_reg <= res;
    end
  end

  assign response.valid          = out_valid;
  assign response.pop_valid      = out_reg.pop_valid;
  assign response.out_key        = out_reg.out_key;
  assign response.out_value      = out_reg.out_value;
  assign response.merged         = out_reg.merged;
  assign response.dropped_oldest = out_reg.dropped_oldest;
  assign response.occupancy      = out_reg.occupancy;

endmodule

// File: tb/ccq_result_checker.sv
// Result checker for the coalescing command queue: follows both channels, keeps
// its own copy of the key/value ring and compares every response transfer.
// Depends on ccq_pkg and the channel interfaces in ccq_if.
`timescale 1ns / 1ps

module ccq_result_checker (
  input  logic clk,
  input  logic rst,
  ccq_req_if   request,
  ccq_rsp_if   response,
  output int   mismatches,
  output int   outstanding
);
  import ccq_pkg::*;

  localparam int SLOTS = QUEUE_SLOTS_DEF;

  // Shadow ring; one slot always stays free
  logic [KEY_W-1:0] ring_key [SLOTS];
  logic [VAL_W-1:0] ring_val [SLOTS];
  int               head_slot;
  int               tail_slot;
  result_t          pending_results [$];

  function automatic int ring_inc(int p);
    return (p + 1) % SLOTS;
  endfunction

  // Apply one command to the shadow ring and return the result it should give
  function automatic result_t apply_command(cmd_e_t cmd, logic [KEY_W-1:0] k,
                                            logic [VAL_W-1:0] v);
    result_t r;
    int      p;
    bit      hit;
    r   = '0;
    hit = 1'b0;
    if (cmd == CMD_PUSH) begin
      // oldest-first search for the same key
      p = head_slot;
      while (p != tail_slot && !hit) begin
        if (ring_key[p] == k) begin
          ring_val[p] = v;
          hit         = 1'b1;
        end else begin
          p = ring_inc(p);
        end
      end
      if (hit) begin
        r.merged = 1'b1;
      end else begin
        // full: make room by losing the oldest pair
        if (ring_inc(tail_slot) == head_slot) begin
          head_slot        = ring_inc(head_slot);
          r.dropped_oldest = 1'b1;
        end
        ring_key[tail_slot] = k;
        ring_val[tail_slot] = v;
        tail_slot           = ring_inc(tail_slot);
      end
    end else if (head_slot != tail_slot) begin
      r.pop_valid = 1'b1;
      r.out_key   = ring_key[head_slot];
      r.out_value = ring_val[head_slot];
      head_slot   = ring_inc(head_slot);
    end
    r.occupancy = OCC_W'((tail_slot + SLOTS - head_slot) % SLOTS);
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Predict on each request transfer, check on each response transfer
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      head_slot = 0;
      tail_slot = 0;
      pending_results.delete();
    end else begin
      if (response.valid && response.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: response transfer expected none, got key %0h value %0h",
                   $time, response.out_key, response.out_value);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compare_field("pop_valid", want.pop_valid, response.pop_valid);
          compare_field("out_key", want.out_key, response.out_key);
          compare_field("out_value", want.out_value, response.out_value);
          compare_field("merged", want.merged, response.merged);
          compare_field("dropped_oldest", want.dropped_oldest, response.dropped_oldest);
          compare_field("occupancy", want.occupancy, response.occupancy);
        end
      end
      if (request.valid && request.ready) begin
        pending_results.push_back(apply_command(cmd_e_t'(request.command), request.key,
                                                request.value));
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

// File: tb/tb_coalescing_command_queue.sv
// Top of the coalescing command queue testbench: clock, reset, request and
// response stall generation. Depends on ccq_pkg, ccq_if, the RTL and ccq_result_checker.
`timescale 1ns / 1ps

module tb_coalescing_command_queue;
  import ccq_pkg::*;

  logic clk;
  logic rst;
  int   idle_pct;
  int   mismatches;
  int   outstanding;

  ccq_req_if request ();
  ccq_rsp_if response ();

  coalescing_command_queue i_dut (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .response (response)
  );

  ccq_result_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .request     (request),
    .response    (response),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #1_000_000;
    $display("coalescing_command_queue: mismatch");
    $finish;
  end

  // Receiver stalls; held off during reset
  always @(posedge clk) begin
    if (rst) begin
      response.ready <= 1'b0;
    end else begin
      response.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // One request transfer, with random idle cycles ahead of it
  task automatic transfer_command(input cmd_e_t cmd, input logic [KEY_W-1:0] k,
                                  input logic [VAL_W-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      request.valid <= 1'b0;
      @(posedge clk);
    end
    request.valid   <= 1'b1;
    request.command <= cmd;
    request.key     <= k;
    request.value   <= v;
    @(posedge clk);
    while (!request.ready) @(posedge clk);
  endtask

  task automatic push_pair(input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v);
    transfer_command(CMD_PUSH, k, v);
  endtask

  // key and value carry noise on a pop; the block must ignore them
  task automatic pop_oldest();
    transfer_command(CMD_POP, KEY_W'($urandom), VAL_W'($urandom));
  endtask

  // Mostly a small key pool so merges, full rings and drops happen often
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0: return KEY_W'($urandom);
      1: return $urandom_range(1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
      default: return KEY_W'($urandom_range(11));
    endcase
  endfunction

  initial begin
    int pop_pct;
    rst              <= 1'b1;
    request.valid    <= 1'b0;
    request.command  <= CMD_PUSH;
    request.key      <= '0;
    request.value    <= '0;
    idle_pct         <= 11;
    pop_pct          = 50;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty pop, extreme keys/values, merges at both ends
    pop_oldest();
    push_pair(16'h0000, 16'h0000);
    push_pair(16'hffff, 16'hffff);
    push_pair(16'h0000, 16'hffff);
    push_pair(16'hffff, 16'h0000);
    pop_oldest();
    pop_oldest();
    // fill to capacity, overflow, merge while full, then drain past empty
    for (int k = 1; k <= 7; k++) push_pair(KEY_W'(k), VAL_W'($urandom));
    push_pair(16'd8, 16'h8888);
    push_pair(16'd8, 16'h1234);
    push_pair(16'd5, 16'habcd);
    repeat (8) pop_oldest();

    // Random: phases that lean toward pushes, pops or neither
    for (int i = 0; i < 1700; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0: pop_pct = 15;
          1: pop_pct = 50;
          default: pop_pct = 80;
        endcase
      end
      if (i == 800) idle_pct <= 0;
      if (i == 1100) idle_pct <= 11;
      if ($urandom_range(99) < pop_pct) pop_oldest();
      else push_pair(pick_key(), VAL_W'($urandom));
    end
    request.valid <= 1'b0;

    // Drain, then let the slowest scan finish
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("coalescing_command_queue: match");
    end else begin
      $display("coalescing_command_queue: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/ccq_pkg.sv
rtl/ccq_if.sv
rtl/ccq_mem.sv
rtl/ccq_seq.sv
rtl/coalescing_command_queue.sv
tb/ccq_result_checker.sv
tb/tb_coalescing_command_queue.sv
